// ----- hdl/ce2s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Calendar to epoch seconds package
// Shared widths, calendar constants, stage words and the month table.
// ---------------------------------------------------------------------------
package ce2s_pkg;

    localparam int YEAR_W   = 8;
    localparam int MONTH_W  = 7;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int EPOCH_W  = 32;

    localparam int NUM_STAGES = 5;

    localparam int Y_W        = 9;
    localparam int MIDX_W     = 4;
    localparam int DAYS_W     = 18;
    localparam int MDAYS_W    = 10;
    localparam int HM_W       = 11;
    localparam int SECPART_W  = 18;

    localparam int CAL_MONTHS        = 12;
    localparam int MONTH_RECIP       = 171;
    localparam int MONTH_RECIP_SHIFT = 11;
    localparam int EPOCH_YEAR_OFS    = 70;
    localparam int LEAP_BASE_OFS     = 68;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int CENTURY_SKIP_OFS  = 200;
    localparam int MINUTES_PER_HOUR  = 60;
    localparam int SECONDS_PER_MIN   = 60;
    localparam int SECONDS_PER_HOUR  = 3600;
    localparam int SECONDS_PER_DAY   = 86400;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef struct packed {
        logic [Y_W-1:0]      years;
        logic [MIDX_W-1:0]   month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                daylight;
    } split_word_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0]  year_days;
        logic signed [MDAYS_W-1:0] month_days;
        logic [HOUR_W-1:0]         hour;
        logic [MINUTE_W-1:0]       minute;
        logic [SECOND_W-1:0]       second;
        logic                      daylight;
    } date_word_t;

    function automatic logic [8:0] days_before_month(input logic [MIDX_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ce2s_cal_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Calendar input channel
// Valid/ready channel that carries one broken-down UTC date and time word.
// ---------------------------------------------------------------------------
interface ce2s_cal_if
    import ce2s_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   years_since_1900;
    logic [MONTH_W-1:0]  month_index;
    logic [DAY_W-1:0]    day_of_month;
    logic [HOUR_W-1:0]   hour_of_day;
    logic [MINUTE_W-1:0] minute_of_hour;
    logic [SECOND_W-1:0] second_of_minute;
    logic                daylight_flag;

    modport source (
        output valid, years_since_1900, month_index, day_of_month, hour_of_day,
               minute_of_hour, second_of_minute, daylight_flag,
        input  ready
    );
    modport sink (
        input  valid, years_since_1900, month_index, day_of_month, hour_of_day,
               minute_of_hour, second_of_minute, daylight_flag,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/ce2s_epoch_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Epoch output channel
// Valid/ready channel that carries one 32-bit epoch seconds word.
// ---------------------------------------------------------------------------
interface ce2s_epoch_if
    import ce2s_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, epoch_seconds, input ready);
    modport sink (input valid, epoch_seconds, output ready);
endinterface
`default_nettype wire

// ----- hdl/ce2s_date.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Date stages
// Stage one folds the month count into the year; stage two forms the day
// count of the year start and the day offset within the year.
// ---------------------------------------------------------------------------
module ce2s_date
    import ce2s_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [1:0]          en,
    input  wire logic                in_valid,
    input  wire logic [YEAR_W-1:0]   years_since_1900,
    input  wire logic [MONTH_W-1:0]  month_index,
    input  wire logic [DAY_W-1:0]    day_of_month,
    input  wire logic [HOUR_W-1:0]   hour_of_day,
    input  wire logic [MINUTE_W-1:0] minute_of_hour,
    input  wire logic [SECOND_W-1:0] second_of_minute,
    input  wire logic                daylight_flag,
    output logic [1:0]               valid,
    output date_word_t               date_word
);

    localparam int PROD_W = MONTH_W + 8;

    logic [1:0]          valid_reg;
    logic [1:0]          valid_next;
    split_word_t         split_reg;
    split_word_t         split_next;
    date_word_t          date_reg;
    date_word_t          date_next;

    logic [PROD_W-1:0]   mon_prod;
    logic [MIDX_W-1:0]   mon_quot;
    logic [MONTH_W-1:0]  mon_rem;

    logic signed [DAYS_W-1:0] y_ext;
    logic signed [DAYS_W-1:0] base_days;
    logic signed [DAYS_W-1:0] leap_days;
    logic                     century_skip;
    logic                     leap_year;
    logic                     early_month;

    always_comb
    begin
        mon_prod = PROD_W'(month_index) * PROD_W'(MONTH_RECIP);
        mon_quot = MIDX_W'(mon_prod >> MONTH_RECIP_SHIFT);
        mon_rem  = month_index - MONTH_W'(mon_quot) * MONTH_W'(CAL_MONTHS);

        split_next.years    = Y_W'(years_since_1900) + Y_W'(mon_quot);
        split_next.month    = mon_rem[MIDX_W-1:0];
        split_next.day      = day_of_month;
        split_next.hour     = hour_of_day;
        split_next.minute   = minute_of_hour;
        split_next.second   = second_of_minute;
        split_next.daylight = daylight_flag;
    end

    always_comb
    begin
        y_ext     = DAYS_W'(split_reg.years);
        base_days = (y_ext - DAYS_W'(EPOCH_YEAR_OFS)) * DAYS_W'(DAYS_PER_YEAR);

        // Leap count since 1968 truncates toward zero for earlier years.
        if (split_reg.years >= Y_W'(LEAP_BASE_OFS))
        begin
            leap_days = DAYS_W'((split_reg.years - Y_W'(LEAP_BASE_OFS)) >> 2);
        end
        else
        begin
            leap_days = -DAYS_W'((Y_W'(LEAP_BASE_OFS) - split_reg.years) >> 2);
        end

        // Of the century years in range, 1900 and 2100 are not leap years.
        century_skip = (split_reg.years >= Y_W'(CENTURY_SKIP_OFS));
        leap_year    = (split_reg.years[1:0] == 2'b00) && (split_reg.years != '0)
                       && (split_reg.years != Y_W'(CENTURY_SKIP_OFS));
        early_month  = (split_reg.month < MIDX_W'(2));

        date_next.year_days  = base_days + leap_days - DAYS_W'(century_skip);
        date_next.month_days = MDAYS_W'(days_before_month(split_reg.month))
                               + MDAYS_W'(split_reg.day) - MDAYS_W'(1)
                               - MDAYS_W'(leap_year && early_month);
        date_next.hour       = split_reg.hour;
        date_next.minute     = split_reg.minute;
        date_next.second     = split_reg.second;
        date_next.daylight   = split_reg.daylight;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        if (en[1])
        begin
            valid_next[1] = valid_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            split_reg <= split_next;
        end
        if (en[1])
        begin
            date_reg <= date_next;
        end
    end

    assign valid     = valid_reg;
    assign date_word = date_reg;

endmodule
`default_nettype wire

// ----- hdl/ce2s_seconds.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Seconds stages
// Sums the day count, scales it to seconds with one multiplier, and adds
// the time of day less the daylight hour into the 32-bit result register.
// ---------------------------------------------------------------------------
module ce2s_seconds
    import ce2s_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [2:0]   en,
    input  wire logic         in_valid,
    input  wire date_word_t   date_word,
    output logic [2:0]        valid,
    output logic [EPOCH_W-1:0] epoch_seconds
);

    logic [2:0]                  valid_reg;
    logic [2:0]                  valid_next;

    logic signed [DAYS_W-1:0]    days_reg;
    logic signed [DAYS_W-1:0]    days_next;
    logic [HM_W-1:0]             hm_reg;
    logic [HM_W-1:0]             hm_next;
    logic [SECOND_W-1:0]         sec_reg;
    logic                        dst_reg;

    logic [EPOCH_W-1:0]          day_secs_reg;
    logic [EPOCH_W-1:0]          day_secs_next;
    logic signed [SECPART_W-1:0] tod_reg;
    logic signed [SECPART_W-1:0] tod_next;

    logic [EPOCH_W-1:0]          epoch_reg;
    logic [EPOCH_W-1:0]          epoch_next;

    always_comb
    begin
        days_next = date_word.year_days
                    + {{(DAYS_W-MDAYS_W){date_word.month_days[MDAYS_W-1]}},
                       date_word.month_days};
        hm_next   = HM_W'(date_word.hour) * HM_W'(MINUTES_PER_HOUR)
                    + HM_W'(date_word.minute);

        day_secs_next = {{(EPOCH_W-DAYS_W){days_reg[DAYS_W-1]}}, days_reg}
                        * EPOCH_W'(SECONDS_PER_DAY);
        tod_next      = SECPART_W'(hm_reg) * SECPART_W'(SECONDS_PER_MIN)
                        + SECPART_W'(sec_reg)
                        - (dst_reg ? SECPART_W'(SECONDS_PER_HOUR) : SECPART_W'(0));

        epoch_next = day_secs_reg
                     + {{(EPOCH_W-SECPART_W){tod_reg[SECPART_W-1]}}, tod_reg};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        if (en[1])
        begin
            valid_next[1] = valid_reg[0];
        end
        if (en[2])
        begin
            valid_next[2] = valid_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            days_reg <= days_next;
            hm_reg   <= hm_next;
            sec_reg  <= date_word.second;
            dst_reg  <= date_word.daylight;
        end
        if (en[1])
        begin
            day_secs_reg <= day_secs_next;
            tod_reg      <= tod_next;
        end
        if (en[2])
        begin
            epoch_reg <= epoch_next;
        end
    end

    assign valid         = valid_reg;
    assign epoch_seconds = epoch_reg;

endmodule
`default_nettype wire

// ----- hdl/calendar_to_epoch_seconds.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while the output accepts; five register stages,
// each a constant multiply or a few narrow adds (day count by 86400 in stage four).
// A stage whose word is not yet taken holds it, and bubbles ahead of it close up.
// Reset (rst_n low, asynchronous) empties all stages; data registers are not cleared.
// ---------------------------------------------------------------------------
// Calendar to epoch seconds
// Converts a broken-down UTC date and time into the low 32 bits of the
// signed seconds count since 1970-01-01.
// ---------------------------------------------------------------------------
module calendar_to_epoch_seconds
    import ce2s_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ce2s_cal_if.sink      cal,
    ce2s_epoch_if.source  epoch
);

    stage_vec_t v;
    stage_vec_t en;
    date_word_t date_word;

    always_comb
    begin
        en[NUM_STAGES-1] = !v[NUM_STAGES-1] || epoch.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v[k] || en[k+1];
        end
    end

    assign cal.ready   = en[0];
    assign epoch.valid = v[NUM_STAGES-1];

    ce2s_date u_date (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en[1:0]),
        .in_valid         (cal.valid),
        .years_since_1900 (cal.years_since_1900),
        .month_index      (cal.month_index),
        .day_of_month     (cal.day_of_month),
        .hour_of_day      (cal.hour_of_day),
        .minute_of_hour   (cal.minute_of_hour),
        .second_of_minute (cal.second_of_minute),
        .daylight_flag    (cal.daylight_flag),
        .valid            (v[1:0]),
        .date_word        (date_word)
    );

    ce2s_seconds u_seconds (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en[4:2]),
        .in_valid      (v[1]),
        .date_word     (date_word),
        .valid         (v[4:2]),
        .epoch_seconds (epoch.epoch_seconds)
    );

`ifndef SYNTHESIS
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v == '0) |-> cal.ready)
        else $error("empty pipeline refuses a word");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v) == $countones($past(v))
            + $past(cal.valid && cal.ready) - $past(epoch.valid && epoch.ready)))
        else $error("word lost or repeated in pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v[3] && !en[3]) |=> v[3])
        else $error("stalled stage dropped its word");
`endif

endmodule
`default_nettype wire

// ----- verif/epoch_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Epoch seconds checker
// Watches the calendar and epoch channels, computes the epoch word each
// accepted calendar word must produce, and compares the results in order.
// ---------------------------------------------------------------------------
module epoch_checker
    import ce2s_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ce2s_cal_if    cal,
    ce2s_epoch_if  epoch,
    output int     failures,
    output int     pending
);

    localparam int REPORT_LIMIT = 10;
    localparam int CUM_DAYS [CAL_MONTHS] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic [EPOCH_W-1:0] expected_epochs [$];
    logic [EPOCH_W-1:0] oldest_epoch;

    function automatic logic [EPOCH_W-1:0] predict_epoch(
        input logic [YEAR_W-1:0]   yoff,
        input logic [MONTH_W-1:0]  mon,
        input logic [DAY_W-1:0]    mday,
        input logic [HOUR_W-1:0]   hh,
        input logic [MINUTE_W-1:0] mm,
        input logic [SECOND_W-1:0] ss,
        input logic                dst
    );
        longint year;
        longint month_in_year;
        longint days;
        longint total;
        month_in_year = longint'(mon) % CAL_MONTHS;
        year = 1900 + longint'(yoff) + longint'(mon) / CAL_MONTHS;
        days = (year - 1970) * DAYS_PER_YEAR + CUM_DAYS[month_in_year];
        // Division truncates toward zero, which matters for years before 1968.
        days += (year - 1968) / 4;
        days -= (year - 1900) / 100;
        days += (year - 1600) / 400;
        if ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0))
            && (month_in_year < 2))
        begin
            days -= 1;
        end
        days += longint'(mday) - 1;
        total = ((days * 24 + longint'(hh)) * MINUTES_PER_HOUR + longint'(mm))
                * SECONDS_PER_MIN + longint'(ss);
        if (dst)
        begin
            total -= SECONDS_PER_HOUR;
        end
        return total[EPOCH_W-1:0];
    endfunction

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (epoch.valid && epoch.ready)
            begin
                if (expected_epochs.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected epoch word %h", $realtime,
                                 epoch.epoch_seconds);
                    end
                end
                else
                begin
                    oldest_epoch = expected_epochs.pop_front();
                    if (epoch.epoch_seconds !== oldest_epoch)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display("%0t: epoch_seconds expected %h actual %h",
                                     $realtime, oldest_epoch, epoch.epoch_seconds);
                        end
                    end
                end
            end
            if (cal.valid && cal.ready)
            begin
                expected_epochs.push_back(predict_epoch(cal.years_since_1900,
                    cal.month_index, cal.day_of_month, cal.hour_of_day,
                    cal.minute_of_hour, cal.second_of_minute, cal.daylight_flag));
            end
            pending = expected_epochs.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar to epoch seconds testbench
// Sends directed and random calendar words with bursty input and a stalling
// output, and reports the verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module testbench;
    import ce2s_pkg::*;

    localparam int NUM_RANDOM_WORDS = 1500;
    localparam int IDLE_LIMIT       = 2000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES     = 20;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   idle_cycles;
    int   hold_requests;
    int   holds_done;
    int   burst_left;

    ce2s_cal_if   cal ();
    ce2s_epoch_if epoch ();

    calendar_to_epoch_seconds DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cal   (cal),
        .epoch (epoch)
    );

    epoch_checker checker_inst (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal      (cal),
        .epoch    (epoch),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_word(
        input logic [YEAR_W-1:0]   yoff,
        input logic [MONTH_W-1:0]  mon,
        input logic [DAY_W-1:0]    mday,
        input logic [HOUR_W-1:0]   hh,
        input logic [MINUTE_W-1:0] mm,
        input logic [SECOND_W-1:0] ss,
        input logic                dst
    );
        @(negedge clk);
        cal.valid            <= 1'b1;
        cal.years_since_1900 <= yoff;
        cal.month_index      <= mon;
        cal.day_of_month     <= mday;
        cal.hour_of_day      <= hh;
        cal.minute_of_hour   <= mm;
        cal.second_of_minute <= ss;
        cal.daylight_flag    <= dst;
        @(posedge clk);
        while (!cal.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_input(input int cycles);
        @(negedge clk);
        cal.valid            <= 1'b0;
        cal.years_since_1900 <= YEAR_W'($urandom);
        cal.month_index      <= MONTH_W'($urandom);
        cal.day_of_month     <= DAY_W'($urandom);
        cal.hour_of_day      <= HOUR_W'($urandom);
        cal.minute_of_hour   <= MINUTE_W'($urandom);
        cal.second_of_minute <= SECOND_W'($urandom);
        cal.daylight_flag    <= 1'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_random_word();
        logic [YEAR_W-1:0]   yoff;
        logic [MONTH_W-1:0]  mon;
        logic [DAY_W-1:0]    mday;
        logic [HOUR_W-1:0]   hh;
        logic [MINUTE_W-1:0] mm;
        logic [SECOND_W-1:0] ss;
        yoff = YEAR_W'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            mon  = MONTH_W'($urandom_range(0, 11));
            mday = DAY_W'($urandom_range(1, 31));
            hh   = HOUR_W'($urandom_range(0, 23));
            mm   = MINUTE_W'($urandom_range(0, 59));
            ss   = SECOND_W'($urandom_range(0, 60));
        end
        else
        begin
            mon  = MONTH_W'($urandom);
            mday = DAY_W'($urandom);
            hh   = HOUR_W'($urandom);
            mm   = MINUTE_W'($urandom);
            ss   = SECOND_W'($urandom);
        end
        send_word(yoff, mon, mday, hh, mm, ss, 1'($urandom));
    endtask

    // Output side: alternating ready patterns, plus long hold-offs on request.
    initial
    begin
        int mode;
        int span;
        holds_done  = 0;
        epoch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                if (hold_requests != holds_done)
                begin
                    epoch.ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(negedge clk);
                    holds_done++;
                end
                case (mode)
                    0:       epoch.ready <= 1'b1;
                    1:       epoch.ready <= 1'($urandom);
                    2:       epoch.ready <= ($urandom_range(0, 3) == 0);
                    default: epoch.ready <= (i % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cal.valid && cal.ready) || (epoch.valid && epoch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        idle_cycles          = 0;
        hold_requests        = 0;
        cal.valid            = 1'b0;
        cal.years_since_1900 = '0;
        cal.month_index      = '0;
        cal.day_of_month     = '0;
        cal.hour_of_day      = '0;
        cal.minute_of_hour   = '0;
        cal.second_of_minute = '0;
        cal.daylight_flag    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The epoch itself, the far ends of every field, and all-zero fields.
        send_word(8'd70, 7'd0, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd0, 7'd0, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd255, 7'd127, 5'd31, 5'd31, 6'd63, 6'd63, 1'b1);
        send_word(8'd255, 7'd127, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0);
        send_word(8'd0, 7'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd0, 7'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b1);
        // Leap years before and after March, and century years.
        send_word(8'd100, 7'd1, 5'd29, 5'd12, 6'd30, 6'd15, 1'b0);
        send_word(8'd100, 7'd2, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd72, 7'd0, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd68, 7'd1, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0);
        send_word(8'd0, 7'd1, 5'd28, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd200, 7'd0, 5'd15, 5'd6, 6'd0, 6'd0, 1'b1);
        send_word(8'd4, 7'd0, 5'd10, 5'd0, 6'd0, 6'd0, 1'b0);
        // Years before 1968, where the leap term truncates toward zero.
        send_word(8'd67, 7'd5, 5'd20, 5'd8, 6'd45, 6'd30, 1'b0);
        send_word(8'd1, 7'd11, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1);
        // Month counts that carry into the year.
        send_word(8'd99, 7'd12, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd99, 7'd13, 5'd29, 5'd0, 6'd0, 6'd0, 1'b0);
        send_word(8'd90, 7'd120, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0);
        // Leap second, the last second before 1970, and the 32-bit boundaries.
        send_word(8'd116, 7'd11, 5'd31, 5'd23, 6'd59, 6'd60, 1'b0);
        send_word(8'd69, 7'd11, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0);
        send_word(8'd138, 7'd0, 5'd19, 5'd3, 6'd14, 6'd8, 1'b0);
        send_word(8'd1, 7'd11, 5'd13, 5'd20, 6'd45, 6'd52, 1'b0);
        send_word(8'd70, 7'd0, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1);

        wait_drained();

        // The output holds off while words keep coming, so the block fills up.
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 60; i++)
        begin
            send_random_word();
        end

        burst_left = 0;
        for (int i = 0; i < NUM_RANDOM_WORDS; i++)
        begin
            if (i == NUM_RANDOM_WORDS / 2)
            begin
                wait_drained();
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    idle_input($urandom_range(30, 60));
                end
                else
                begin
                    idle_input($urandom_range(1, 12));
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 150)
                                                         : $urandom_range(1, 40);
            end
            send_random_word();
            burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
